// ===== src/pdd_pkg.sv =====
// Shared types and constants for the push-dim pulse decoder.
`default_nettype none

package pdd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int RUN_W       = 8;
    localparam int ACTIVE_W    = 16;
    localparam int EVENT_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_QUALIFY  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_QUALIFY  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TIMEOUT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_FIRST   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_REPEAT  = 3'd4;

    // Reset values of the configuration registers
    localparam logic [RUN_W-1:0]    LOW_QUALIFY_RST = 8'd3;
    localparam logic [RUN_W-1:0]    GAP_QUALIFY_RST = 8'd6;
    localparam logic [RUN_W-1:0]    GAP_TIMEOUT_RST = 8'd51;
    localparam logic [ACTIVE_W-1:0] LONG_FIRST_RST  = 16'd1001;
    localparam logic [ACTIVE_W-1:0] LONG_REPEAT_RST = 16'd301;

    localparam logic [RUN_W-1:0]    RUN_MAX    = {RUN_W{1'b1}};
    localparam logic [ACTIVE_W-1:0] ACTIVE_MAX = {ACTIVE_W{1'b1}};

    // Event codes
    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_TOGGLE = 2'd1;
    localparam logic [EVENT_W-1:0] EV_STEP   = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_FIRST_LOW = 5'b00010,
        PH_GAP       = 5'b00100,
        PH_ACTIVE    = 5'b01000,
        PH_LONG      = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [RUN_W-1:0]    low_qualify;
        logic [RUN_W-1:0]    gap_qualify;
        logic [RUN_W-1:0]    gap_timeout;
        logic [ACTIVE_W-1:0] long_first;
        logic [ACTIVE_W-1:0] long_repeat;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [RUN_W-1:0]    low_run;
        logic [RUN_W-1:0]    high_run;
        logic [ACTIVE_W-1:0] active_low_count;
        logic                direction_up;
    } dec_state_t;

endpackage

`default_nettype wire

// ===== src/pdd_sample_if.sv =====
// Input channel carrying one sampled line level per transaction.
`default_nettype none

interface pdd_sample_if;
    logic valid;
    logic ready;
    logic line_high;

    modport source (output valid, output line_high, input ready);
    modport sink (input valid, input line_high, output ready);
endinterface

`default_nettype wire

// ===== src/pdd_result_if.sv =====
// Output channel carrying one decoded event per transaction.
`default_nettype none

interface pdd_result_if;
    import pdd_pkg::*;
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_code;
    logic               dim_up;

    modport source (output valid, output event_code, output dim_up, input ready);
    modport sink (input valid, input event_code, input dim_up, output ready);
endinterface

`default_nettype wire

// ===== src/pdd_cfg_if.sv =====
// Configuration write channel: register index and write data.
`default_nettype none

interface pdd_cfg_if;
    import pdd_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/push_dim_pulse_decoder_core.sv =====
// Top level of the push-dim pulse decoder core.
// Usage:
//   sample_ch  - one transaction per timer tick carrying the sampled line level
//                (line_high = 1 means the line is high).
//   result_ch  - exactly one transaction per accepted sample: event_code
//                (none, toggle or level step) and dim_up, the dimming direction
//                after that tick.
//   cfg_ch     - register writes, index 0..4 in the order low_qualify,
//                gap_qualify, gap_timeout, long_first, long_repeat. Always ready;
//                indexes above 4 are ignored. Write only while the core is idle.
// Latency: the result of a sample is valid in the cycle after it is accepted.
// Throughput: one sample per cycle when not stalled; the whole decode of a sample
//   is one pass through the step logic into the state and result registers.
// Reset: the phase returns to idle, all run counters clear, the direction is
//   down and the registers take their default values. No result is pending.
// Stall: the result register holds while the receiver stalls; a new sample is
//   still accepted in the cycle the held result is taken.
`default_nettype none

module push_dim_pulse_decoder_core
    import pdd_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    pdd_sample_if.sink  sample_ch,
    pdd_result_if.source result_ch,
    pdd_cfg_if.sink     cfg_ch
);

    cfg_t               cfg;
    dec_state_t         state_reg;
    dec_state_t         state_next;
    logic [EVENT_W-1:0] event_next;
    logic               sample_accept;

    logic               out_valid_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic               out_dim_up_reg;

    pdd_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    pdd_step u_step (
        .cur        (state_reg),
        .line_high  (sample_ch.line_high),
        .cfg        (cfg),
        .nxt        (state_next),
        .event_code (event_next)
    );

    // Take a new sample whenever the result register is empty or being drained.
    assign sample_ch.ready = !out_valid_reg || result_ch.ready;
    assign sample_accept   = sample_ch.valid && sample_ch.ready;

    assign result_ch.valid      = out_valid_reg;
    assign result_ch.event_code = out_event_reg;
    assign result_ch.dim_up     = out_dim_up_reg;

    // Advance the decoder state only on an accepted sample.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase            <= PH_IDLE;
            state_reg.low_run          <= '0;
            state_reg.high_run         <= '0;
            state_reg.active_low_count <= '0;
            state_reg.direction_up     <= 1'b0;
        end
        else if (sample_accept)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (sample_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload needs no reset; it is qualified by out_valid_reg.
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            out_event_reg  <= event_next;
            out_dim_up_reg <= state_next.direction_up;
        end
    end

`ifndef SYNTH
    // A level step always leaves the decoder in the long phase with a fresh count.
    a_step_to_long: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_accept && event_next == EV_STEP) |=>
            (state_reg.phase == PH_LONG && state_reg.active_low_count == '0))
        else $error("level step without entering long phase");

    // A toggle ends the activity.
    a_toggle_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_accept && event_next == EV_TOGGLE) |=> state_reg.phase == PH_IDLE)
        else $error("toggle without dropping to idle");

    // The direction flips only when a long activation ends.
    a_dir_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_accept && state_next.direction_up != state_reg.direction_up) |=>
            (state_reg.phase == PH_IDLE && state_reg.high_run == '0))
        else $error("direction changed outside a long release");

    // The low and high runs never count at the same time.
    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.low_run != '0 && state_reg.high_run != '0))
        else $error("low and high runs both nonzero");

    // An empty result register never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample_ch.ready)
        else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

// ===== src/pdd_cfg_regs.sv =====
// Configuration register file of the push-dim pulse decoder.
`default_nettype none

module pdd_cfg_regs
    import pdd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    pdd_cfg_if.sink   cfg_ch,
    output cfg_t      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ch.ready = 1'b1;
    assign cfg         = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_LOW_QUALIFY: cfg_next.low_qualify = cfg_ch.data[RUN_W-1:0];
                CFG_GAP_QUALIFY: cfg_next.gap_qualify = cfg_ch.data[RUN_W-1:0];
                CFG_GAP_TIMEOUT: cfg_next.gap_timeout = cfg_ch.data[RUN_W-1:0];
                CFG_LONG_FIRST:  cfg_next.long_first  = cfg_ch.data[ACTIVE_W-1:0];
                CFG_LONG_REPEAT: cfg_next.long_repeat = cfg_ch.data[ACTIVE_W-1:0];
                default:         cfg_next = cfg_reg; // drop out-of-range writes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_qualify <= LOW_QUALIFY_RST;
            cfg_reg.gap_qualify <= GAP_QUALIFY_RST;
            cfg_reg.gap_timeout <= GAP_TIMEOUT_RST;
            cfg_reg.long_first  <= LONG_FIRST_RST;
            cfg_reg.long_repeat <= LONG_REPEAT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pdd_step.sv =====
// Next-state and event logic for one sampled line level.
`default_nettype none

module pdd_step
    import pdd_pkg::*;
(
    input  wire dec_state_t    cur,
    input  wire logic          line_high,
    input  wire cfg_t          cfg,
    output dec_state_t         nxt,
    output logic [EVENT_W-1:0] event_code
);

    logic [RUN_W-1:0]    low_inc;
    logic [RUN_W-1:0]    high_inc;
    logic [ACTIVE_W-1:0] active_inc;
    logic                drop;

    assign low_inc    = (cur.low_run == RUN_MAX) ? cur.low_run : cur.low_run + 1'b1;
    assign high_inc   = (cur.high_run == RUN_MAX) ? cur.high_run : cur.high_run + 1'b1;
    assign active_inc = (cur.active_low_count == ACTIVE_MAX) ? cur.active_low_count
                                                             : cur.active_low_count + 1'b1;

    always_comb
    begin
        nxt        = cur;
        event_code = EV_NONE;
        drop       = 1'b0;
        if (line_high)
        begin
            nxt.low_run  = '0;
            nxt.high_run = high_inc;
            case (cur.phase)
                PH_IDLE:
                    nxt.active_low_count = '0;
                PH_FIRST_LOW:
                begin
                    if (high_inc >= cfg.gap_timeout)
                        drop = 1'b1;
                    else if (high_inc >= cfg.gap_qualify)
                    begin
                        nxt.phase            = PH_GAP;
                        nxt.active_low_count = '0;
                    end
                end
                PH_GAP:
                    drop = (high_inc >= cfg.gap_timeout);
                PH_ACTIVE:
                begin
                    if (high_inc >= cfg.gap_timeout)
                    begin
                        drop       = 1'b1;
                        event_code = EV_TOGGLE;
                    end
                end
                PH_LONG:
                begin
                    if (high_inc >= cfg.gap_timeout)
                    begin
                        drop             = 1'b1;
                        nxt.direction_up = ~cur.direction_up;
                    end
                end
                default:
                    drop = 1'b1;
            endcase
        end
        else
        begin
            nxt.high_run = '0;
            nxt.low_run  = low_inc;
            case (cur.phase)
                PH_IDLE:
                begin
                    if (low_inc >= cfg.low_qualify)
                    begin
                        nxt.phase            = PH_FIRST_LOW;
                        nxt.active_low_count = '0;
                    end
                end
                PH_FIRST_LOW:
                    nxt.phase = PH_FIRST_LOW;
                PH_GAP:
                begin
                    if (low_inc >= cfg.low_qualify)
                    begin
                        nxt.phase            = PH_ACTIVE;
                        nxt.active_low_count = '0;
                    end
                end
                PH_ACTIVE:
                begin
                    nxt.active_low_count = active_inc;
                    if (active_inc >= cfg.long_first)
                    begin
                        nxt.phase            = PH_LONG;
                        nxt.active_low_count = '0;
                        event_code           = EV_STEP;
                    end
                end
                PH_LONG:
                begin
                    nxt.active_low_count = active_inc;
                    if (active_inc >= cfg.long_repeat)
                    begin
                        nxt.active_low_count = '0;
                        event_code           = EV_STEP;
                    end
                end
                default:
                    drop = 1'b1;
            endcase
        end
        if (drop)
        begin
            nxt.phase            = PH_IDLE;
            nxt.low_run          = '0;
            nxt.high_run         = '0;
            nxt.active_low_count = '0;
        end
    end

endmodule

`default_nettype wire
